>>> design/cpdc_pkg.sv
// ----------------------------------------------------------------------------
// Charge pin duty classifier package
// Shared widths, the measurement word type and the status class function.
// ----------------------------------------------------------------------------
package cpdc_pkg;

    // Width of the high and sample counters.
    localparam int COUNT_WIDTH  = 16;
    // Width of the window length register.
    localparam int CFG_WIDTH    = 16;
    localparam int CMP_WIDTH    = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int STATE_WIDTH  = 3;
    localparam int DUTY_WIDTH   = 7;
    localparam int QUOT_WIDTH   = DUTY_WIDTH;
    localparam int NUM_WIDTH    = COUNT_WIDTH + DUTY_WIDTH;
    localparam int STEP_WIDTH   = $clog2(QUOT_WIDTH);
    localparam int DUTY_SCALE   = 100;
    localparam int FIFO_DEPTH   = 2;
    localparam int PTR_WIDTH    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(1024);
    localparam logic [CMP_WIDTH-1:0] COUNT_MAX    = CMP_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);

    // Duty bounds of the discarded first try (exclusive).
    localparam logic [DUTY_WIDTH-1:0] RETRY_LOW  = DUTY_WIDTH'(40);
    localparam logic [DUTY_WIDTH-1:0] RETRY_HIGH = DUTY_WIDTH'(60);

    typedef enum logic [STATE_WIDTH-1:0] {
        CS_NOT_CHARGING = 3'd0,
        CS_CHARGING     = 3'd1,
        CS_THERM_FAULT  = 3'd2,
        CS_BAD_BATTERY  = 3'd3,
        CS_UNDEFINED    = 3'd4
    } charge_state_t;

    // One closed measurement window.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] high_count;
        logic [COUNT_WIDTH-1:0] sample_count;
    } meas_t;

    // Status class of a duty value; the tests are made in priority order.
    function automatic charge_state_t classify(input logic [DUTY_WIDTH-1:0] duty);
        charge_state_t cls;
        if (duty inside {[7'd98:7'd127]})
            cls = CS_NOT_CHARGING;
        else if (duty inside {[7'd0:7'd2]})
            cls = CS_CHARGING;
        else if (duty inside {[7'd0:7'd8], [7'd92:7'd127]})
            cls = CS_THERM_FAULT;
        else if (duty inside {[7'd0:7'd14], [7'd86:7'd127]})
            cls = CS_BAD_BATTERY;
        else
            cls = CS_UNDEFINED;
        return cls;
    endfunction

endpackage

>>> design/cpdc_if.sv
// ----------------------------------------------------------------------------
// Charge pin duty classifier channels
// Valid/ready channels for pin samples, results and the window register.
// ----------------------------------------------------------------------------
interface cpdc_sample_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface cpdc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] charge_state;
    logic [6:0] duty_percent;

    modport source (output valid, output charge_state, output duty_percent, input ready);
    modport sink   (input valid, input charge_state, input duty_percent, output ready);
endinterface

interface cpdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] window_samples;

    modport source (output valid, output window_samples, input ready);
    modport sink   (input valid, input window_samples, output ready);
endinterface

>>> design/charge_pin_duty_classifier_unit.sv
// ----------------------------------------------------------------------------
// Charge pin duty classifier
// Measures the duty of a charger status pin and reports a status class.
// ----------------------------------------------------------------------------
// Throughput: one pin sample per cycle; the front end never stalls while the
//   two-entry window queue has room.
// The result word is registered from the one-bit-per-cycle duty divider
//   (load, 7 steps, decide); a result word not yet taken holds the divider
//   in its decide step. The divider takes no new window until it is through
//   with the last, so short windows stall sampling once the queue fills.
// Reset: counts, retry flag, queue and result valid clear; window is 1024.
// ----------------------------------------------------------------------------
module charge_pin_duty_classifier_unit
    import cpdc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cpdc_sample_if.sink    sample,
    cpdc_cfg_if.sink       cfg,
    cpdc_result_if.source  result
);

    // Closed windows travel from the counting front end to the divider
    // through a short queue, so counting goes on while a duty is divided out
    // and while a result word waits to be taken.
    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    meas_t push_data, pop_data;

    // The front end counts high samples against the configured window length
    // and emits the high and sample counts of each window as it closes.
    cpdc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    cpdc_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // The back end computes highs * 100 / samples, drops the first window of
    // a measurement whose duty lies strictly between 40 and 60, and otherwise
    // registers the duty and its status class as a result word.
    cpdc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

>>> design/cpdc_front.sv
// ----------------------------------------------------------------------------
// Charge pin duty classifier front end
// Counts pin samples and closes windows into the measurement queue.
// ----------------------------------------------------------------------------
module cpdc_front
    import cpdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cpdc_sample_if.sink          sample,
    cpdc_cfg_if.sink             cfg,
    output logic                 push_valid,
    output meas_t                push_data,
    input  logic                 push_ready
);

    logic [CFG_WIDTH-1:0]   window_reg;
    logic [COUNT_WIDTH-1:0] high_reg, high_next;
    logic [COUNT_WIDTH-1:0] samp_reg, samp_next;
    logic [COUNT_WIDTH-1:0] high_inc, samp_inc;
    logic [CMP_WIDTH-1:0]   win_nz, win_eff;
    logic                   accept, close;

    assign cfg.ready    = 1'b1;
    assign sample.ready = push_ready;
    assign accept       = sample.valid && sample.ready;

    // A zero window acts as one; a window beyond the counter range is clamped.
    always_comb
    begin
        win_nz  = (window_reg == '0) ? CMP_WIDTH'(1) : CMP_WIDTH'(window_reg);
        win_eff = (win_nz > COUNT_MAX) ? COUNT_MAX : win_nz;
    end

    assign high_inc = high_reg + COUNT_WIDTH'(sample.pin_level);
    assign samp_inc = samp_reg + COUNT_WIDTH'(1);
    assign close    = accept && (CMP_WIDTH'(samp_inc) >= win_eff);

    always_comb
    begin
        high_next = high_reg;
        samp_next = samp_reg;
        if (close)
        begin
            high_next = '0;
            samp_next = '0;
        end
        else if (accept)
        begin
            high_next = high_inc;
            samp_next = samp_inc;
        end
    end

    assign push_valid             = close;
    assign push_data.high_count   = high_inc;
    assign push_data.sample_count = samp_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            high_reg   <= '0;
            samp_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                window_reg <= cfg.window_samples;
            high_reg <= high_next;
            samp_reg <= samp_next;
        end
    end

endmodule

>>> design/cpdc_fifo.sv
// ----------------------------------------------------------------------------
// Charge pin duty classifier measurement queue
// Short register queue between the counting front end and the divider.
// ----------------------------------------------------------------------------
module cpdc_fifo
    import cpdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  meas_t push_data,
    output logic  push_ready,
    output logic  pop_valid,
    output meas_t pop_data,
    input  logic  pop_ready
);

    meas_t                entry_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_WIDTH:0]   fill_reg, fill_next;
    logic                 do_push, do_pop;

    assign push_ready = (fill_reg != (PTR_WIDTH+1)'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (PTR_WIDTH+1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (PTR_WIDTH+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_WIDTH'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_WIDTH'(1);
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> design/cpdc_back.sv
// ----------------------------------------------------------------------------
// Charge pin duty classifier back end
// Divides out the duty, applies the retry rule and holds the result word.
// ----------------------------------------------------------------------------
module cpdc_back
    import cpdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  meas_t       pop_data,
    output logic        pop_ready,
    cpdc_result_if.source result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [NUM_WIDTH-1:0]   rem_reg, rem_next;
    logic [NUM_WIDTH-1:0]   dsh_reg, dsh_next;
    logic [QUOT_WIDTH-1:0]  quot_reg, quot_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic                   retry_reg, retry_next;
    logic                   res_valid_reg, res_valid_next;
    charge_state_t          cls_reg, cls_next;
    logic [DUTY_WIDTH-1:0]  duty_reg, duty_next;
    logic                   discard;

    assign pop_ready           = (state_reg == ST_IDLE);
    assign result.valid        = res_valid_reg;
    assign result.charge_state = cls_reg;
    assign result.duty_percent = duty_reg;

    // A duty strictly inside the retry band is dropped once per measurement.
    assign discard = !retry_reg && (quot_reg > RETRY_LOW) && (quot_reg < RETRY_HIGH);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        retry_next     = retry_reg;
        res_valid_next = res_valid_reg && !result.ready;
        cls_next       = cls_reg;
        duty_next      = duty_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    rem_next   = NUM_WIDTH'(pop_data.high_count) * NUM_WIDTH'(DUTY_SCALE);
                    dsh_next   = NUM_WIDTH'(pop_data.sample_count) << (QUOT_WIDTH - 1);
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // One restoring division step per cycle, quotient MSB first.
                if (rem_reg >= dsh_reg)
                begin
                    rem_next  = rem_reg - dsh_reg;
                    quot_next = {quot_reg[QUOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_reg[QUOT_WIDTH-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + STEP_WIDTH'(1);
                if (step_reg == STEP_WIDTH'(QUOT_WIDTH - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (discard)
                begin
                    retry_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    cls_next       = classify(quot_reg);
                    duty_next      = quot_reg;
                    retry_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            retry_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            retry_reg     <= retry_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        cls_reg  <= cls_next;
        duty_reg <= duty_next;
    end

endmodule
